// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the checking code of the bar meter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbph_pkg.sv =====
// ----------------------------------------------------------------------------
// sbph_pkg
// types and constants of the spectrum bar meter with peak hold
// ----------------------------------------------------------------------------
package sbph_pkg;

    // field widths
    localparam int BIN_W   = 8;
    localparam int MAG_W   = 16;
    localparam int SEG_W   = 8;
    localparam int BARNO_W = 4;
    localparam int BIN_CNT = 2 ** BIN_W;

    // default geometry
    localparam int NUM_BARS_DEF     = 16;
    localparam int BINS_PER_BAR_DEF = 14;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_NORM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 1'b1;

    // reset decay rate, 5.0 segments per second in Q8.8
    localparam logic [MAG_W-1:0] DECAY_RESET = 16'd1280;
    // peak marker is drawn below this segment
    localparam logic [SEG_W-1:0] PEAK_LIMIT  = 8'd17;

    // incoming bin word
    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [MAG_W-1:0] raw_mag;
        logic [MAG_W-1:0] norm_mag;
        logic [MAG_W-1:0] frame_time;
    } t_bin_word;

    // outgoing bar word
    typedef struct packed {
        logic [BARNO_W-1:0] bar_number;
        logic [SEG_W-1:0]   lit_segments;
        logic [SEG_W-1:0]   peak_segment;
        logic               peak_shown;
        logic               last_bar;
    } t_bar_word;

    // bar update request from the grouping stage
    typedef struct packed {
        logic [MAG_W-1:0] height;
        logic [MAG_W-1:0] dec;
    } t_bar_req;

endpackage

// ===== hdl/sbph_ram.sv =====
// ----------------------------------------------------------------------------
// sbph_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sbph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a colliding write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sbph_group.sv =====
// ----------------------------------------------------------------------------
// sbph_group
// input register, configuration, bin grouping and running group maximum
// ----------------------------------------------------------------------------
module sbph_group #(
    parameter int NUM_BARS     = 16,
    parameter int BINS_PER_BAR = 14,
    parameter int BAR_W        = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_in_valid,
    input  sbph_pkg::t_bin_word            i_in_word,
    input  logic                           i_cfg_we,
    input  logic [sbph_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_req_valid,
    output logic [BAR_W-1:0]               o_req_bar,
    output sbph_pkg::t_bar_req             o_req
);
    import sbph_pkg::*;

    localparam int POS_W = (BINS_PER_BAR > 1) ? $clog2(BINS_PER_BAR) : 1;
    localparam int unsigned TOTAL = NUM_BARS * BINS_PER_BAR;

    logic             r_use_norm;
    logic [MAG_W-1:0] r_decay;
    logic             r_in_valid;
    t_bin_word        r_in;
    logic [MAG_W-1:0] r_gmax;
    logic [MAG_W-1:0] n_gmax;

    logic [BAR_W-1:0]   bar_lut [BIN_CNT];
    logic [POS_W-1:0]   pos_lut [BIN_CNT];
    logic [BAR_W-1:0]   bin_bar;
    logic [POS_W-1:0]   bin_pos;
    logic               in_range;
    logic               is_last;
    logic [MAG_W-1:0]   sel_mag;
    logic [2*MAG_W-1:0] dec_prod;

    // bin to bar and position tables, folded at elaboration
    for (genvar g = 0; g < BIN_CNT; g++) begin : g_lut
        assign bar_lut[g] = BAR_W'(g / BINS_PER_BAR);
        assign pos_lut[g] = POS_W'(g % BINS_PER_BAR);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_norm <= 1'b0;
            r_decay    <= DECAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_USE_NORM: r_use_norm <= i_cfg_data[0];
                CFG_DECAY:    r_decay    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_in <= i_in_word;
        end
    end

    // grouping and running maximum
    always_comb begin
        bin_bar  = bar_lut[r_in.bin_index];
        bin_pos  = pos_lut[r_in.bin_index];
        in_range = {24'd0, r_in.bin_index} < TOTAL;
        is_last  = bin_pos == POS_W'(BINS_PER_BAR - 1);
        sel_mag  = r_use_norm ? r_in.norm_mag : r_in.raw_mag;
        if ((bin_pos == '0) || (sel_mag > r_gmax)) begin
            n_gmax = sel_mag;
        end else begin
            n_gmax = r_gmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gmax <= '0;
        end else if (i_adv && r_in_valid && in_range) begin
            r_gmax <= is_last ? '0 : n_gmax;
        end
    end

    // decrement, Q8.8 rate times Q0.16 time, truncated to Q8.8
    assign dec_prod = r_decay * r_in.frame_time;

    assign o_req_valid = r_in_valid && in_range && is_last;
    assign o_req_bar   = bin_bar;
    assign o_req       = '{height: n_gmax, dec: dec_prod[2*MAG_W-1:MAG_W]};

endmodule

// ===== hdl/sbph_peak.sv =====
// ----------------------------------------------------------------------------
// sbph_peak
// held peak store, peak raise and decay, and the output register
// ----------------------------------------------------------------------------
module sbph_peak #(
    parameter int NUM_BARS = 16,
    parameter int BAR_W    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [BAR_W-1:0]    i_req_bar,
    input  sbph_pkg::t_bar_req  i_req,
    input  logic                i_out_stall,
    output logic                o_adv,
    output logic                o_out_valid,
    output sbph_pkg::t_bar_word o_out_word
);
    import sbph_pkg::*;

    logic                r_s1_valid;
    logic [BAR_W-1:0]    r_s1_bar;
    t_bar_req            r_s1_req;
    logic                r_s1_vld;
    logic [NUM_BARS-1:0] r_pk_vld;
    logic                r_fwd_valid;
    logic [BAR_W-1:0]    r_fwd_bar;
    logic [MAG_W-1:0]    r_fwd_peak;
    logic                r_out_valid;
    t_bar_word           r_out;

    logic             adv;
    logic [MAG_W-1:0] ram_rdata;
    logic [MAG_W-1:0] old_peak;
    logic [MAG_W-1:0] n_peak;
    t_bar_word        n_out;

    // pipeline moves unless a finished word is held by the consumer
    assign adv = !r_out_valid || !i_out_stall;

    // held peak per bar
    sbph_ram #(
        .WIDTH (MAG_W),
        .DEPTH (NUM_BARS)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_valid),
        .i_waddr (r_s1_bar),
        .i_wdata (n_peak),
        .i_re    (adv),
        .i_raddr (i_req_bar),
        .o_rdata (ram_rdata)
    );

    // peak raise or decay, with bypass of the write made during the read
    always_comb begin
        if (r_fwd_valid && (r_fwd_bar == r_s1_bar)) begin
            old_peak = r_fwd_peak;
        end else if (r_s1_vld) begin
            old_peak = ram_rdata;
        end else begin
            old_peak = '0;
        end
        if (r_s1_req.height > old_peak) begin
            n_peak = r_s1_req.height;
        end else if (r_s1_req.dec >= old_peak) begin
            n_peak = '0;
        end else begin
            n_peak = old_peak - r_s1_req.dec;
        end
        n_out.bar_number   = BARNO_W'(r_s1_bar);
        n_out.lit_segments = r_s1_req.height[MAG_W-1:MAG_W-SEG_W];
        n_out.peak_segment = n_peak[MAG_W-1:MAG_W-SEG_W];
        n_out.peak_shown   = n_peak[MAG_W-1:MAG_W-SEG_W] < PEAK_LIMIT;
        n_out.last_bar     = r_s1_bar == BAR_W'(NUM_BARS - 1);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pk_vld    <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_req_valid;
            r_fwd_valid <= r_s1_valid;
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_pk_vld[r_s1_bar] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_bar   <= i_req_bar;
            r_s1_req   <= i_req;
            r_s1_vld   <= r_pk_vld[i_req_bar];
            r_fwd_bar  <= r_s1_bar;
            r_fwd_peak <= n_peak;
            r_out      <= n_out;
        end
    end

    assign o_adv       = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== hdl/spectrum_bar_peak_hold.sv =====
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold: bar meter with per-bar peak hold
// registers: peak stage, then output, after a bar's last bin is taken
// throughput: one bin per unstalled cycle, set by the peak ram RMW loop
// reset: sync, sets config, clears pipeline valids, group max and peak valids
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_bar_peak_hold #(
    parameter int NUM_BARS     = sbph_pkg::NUM_BARS_DEF,
    parameter int BINS_PER_BAR = sbph_pkg::BINS_PER_BAR_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sbph_pkg::t_bin_word            i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sbph_pkg::t_bar_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [sbph_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbph_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbph_pkg::*;

    localparam int BAR_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;

    logic             adv;
    logic             req_valid;
    logic [BAR_W-1:0] req_bar;
    t_bar_req         req;

    // grouping stage
    sbph_group #(
        .NUM_BARS     (NUM_BARS),
        .BINS_PER_BAR (BINS_PER_BAR),
        .BAR_W        (BAR_W)
    ) u_group (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_req_valid (req_valid),
        .o_req_bar   (req_bar),
        .o_req       (req)
    );

    // peak stage and output register
    sbph_peak #(
        .NUM_BARS (NUM_BARS),
        .BAR_W    (BAR_W)
    ) u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req_bar   (req_bar),
        .i_req       (req),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_stall = !adv;

    // checks
    `SBPH_ASSERT_NOW(a_peak_flag_consistent, i_clk, i_rst_n, o_out_valid, o_out_word.peak_shown == (o_out_word.peak_segment < PEAK_LIMIT), "peak flag disagrees with peak segment")
    `SBPH_ASSERT_NOW(a_stall_only_when_held, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled with no held output word")

endmodule

// ===== dv/tb_spectrum_bar_peak_hold.sv =====
// ----------------------------------------------------------------------------
// tb_spectrum_bar_peak_hold
// self-checking bench for the bar meter with peak hold: bin words are
// queued per phase and sent in bursts while the bar word receiver stalls on
// its own pattern; every accepted bin goes through a bar-height and peak
// predictor, and each bar word is compared field by field with the oldest
// prediction; registers change between phases once the block is idle
// ----------------------------------------------------------------------------
module tb_spectrum_bar_peak_hold;
    import sbph_pkg::*;

    localparam int NUM_BARS     = NUM_BARS_DEF;
    localparam int BINS_PER_BAR = BINS_PER_BAR_DEF;
    localparam int BAR_BINS     = NUM_BARS * BINS_PER_BAR;
    localparam int PHASE_BINS   = 340;
    localparam int SETTLE_CYC   = 8;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BLOCK
    } t_stall_mode;

    // shapes of one random stretch of bins
    typedef enum logic [2:0] {
        SHAPE_FULL,
        SHAPE_SKIP,
        SHAPE_NOISE,
        SHAPE_BARS,
        SHAPE_REVERSED
    } t_frame_shape;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_bin_word             in_word   = '0;
    logic                  out_stall = 1'b1;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_USE_NORM;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_bar_word             out_word;

    // predictor state and register copies
    logic        use_norm_q = 1'b0;
    logic [15:0] decay_q    = DECAY_RESET;
    logic [15:0] grp_max    = '0;
    logic [15:0] peak_lvl [NUM_BARS] = '{default: '0};

    t_bin_word pend_bins [$];
    t_bar_word bar_exp [$];

    int bins_made     = 0;
    int bins_taken    = 0;
    int words_checked = 0;
    int cfg_writes    = 0;
    int mismatches    = 0;

    spectrum_bar_peak_hold uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // bar height and peak hold for one accepted bin
    function automatic void predict_bar(input t_bin_word w);
        logic [15:0] sel;
        logic [15:0] height;
        logic [15:0] pk;
        logic [31:0] drop;
        int          bar;
        int          pos;
        t_bar_word   r;
        if (w.bin_index >= BAR_BINS) return;
        sel = use_norm_q ? w.norm_mag : w.raw_mag;
        bar = w.bin_index / BINS_PER_BAR;
        pos = w.bin_index % BINS_PER_BAR;
        if (pos == 0 || sel > grp_max) grp_max = sel;
        if (pos != BINS_PER_BAR - 1) return;
        height  = grp_max;
        grp_max = '0;
        pk = peak_lvl[bar];
        if (height > pk) begin
            pk = height;
        end else begin
            // Q8.8 rate times Q0.16 time, truncated back to Q8.8
            drop = (32'(decay_q) * 32'(w.frame_time)) >> 16;
            pk = (drop >= 32'(pk)) ? 16'd0 : pk - drop[15:0];
        end
        peak_lvl[bar]  = pk;
        r.bar_number   = bar[BARNO_W-1:0];
        r.lit_segments = height[15:8];
        r.peak_segment = pk[15:8];
        r.peak_shown   = (pk[15:8] < PEAK_LIMIT);
        r.last_bar     = (bar == NUM_BARS - 1);
        bar_exp.insert(bar_exp.size(), r);
    endfunction

    function automatic void flag(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    // bin word driver, bursts with random gaps
    int gap_left   = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_bar(in_word);
                bins_taken++;
            end
            if (in_valid && in_stall) begin
                // hold the stalled word
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pend_bins.size() != 0) begin
                in_word  <= pend_bins.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 4) == 0) ?
                                  $urandom_range(100, 300) : $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_len  = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b1;
        end else begin
            if (stall_len == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                stall_len  <= $urandom_range(20, 200);
            end else begin
                stall_len <= stall_len - 1;
            end
            case (stall_mode)
                STALL_NONE: begin
                    out_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    out_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    out_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    out_stall <= stall_len[3];
                end
            endcase
        end
    end

    // bar word monitor
    always @(posedge i_clk) begin : mon
        t_bar_word want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (bar_exp.size() == 0) begin
                flag("bar word with none pending", '0, 16'(out_word.bar_number));
            end else begin
                want = bar_exp.pop_front();
                if (out_word.bar_number !== want.bar_number)
                    flag("bar_number", 16'(want.bar_number), 16'(out_word.bar_number));
                if (out_word.lit_segments !== want.lit_segments)
                    flag("lit_segments", 16'(want.lit_segments), 16'(out_word.lit_segments));
                if (out_word.peak_segment !== want.peak_segment)
                    flag("peak_segment", 16'(want.peak_segment), 16'(out_word.peak_segment));
                if (out_word.peak_shown !== want.peak_shown)
                    flag("peak_shown", 16'(want.peak_shown), 16'(out_word.peak_shown));
                if (out_word.last_bar !== want.last_bar)
                    flag("last_bar", 16'(want.last_bar), 16'(out_word.last_bar));
                words_checked++;
            end
        end
    end

    task automatic push_bin(input int idx, input logic [15:0] raw, input logic [15:0] norm,
                            input logic [15:0] ftime);
        t_bin_word w;
        w.bin_index  = idx[BIN_W-1:0];
        w.raw_mag    = raw;
        w.norm_mag   = norm;
        w.frame_time = ftime;
        pend_bins.insert(pend_bins.size(), w);
        if (idx < BAR_BINS) bins_made++;
    endtask

    function automatic logic [15:0] pick_mag(input logic [15:0] ceil);
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 16'd0;
        if (k == 1) return ceil;
        return 16'($urandom_range(0, ceil));
    endfunction

    function automatic logic [15:0] pick_time();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic push_rand(input int idx, input logic [15:0] ceil);
        push_bin(idx, pick_mag(ceil), pick_mag(ceil), pick_time());
    endtask

    // one random stretch of bins, mostly complete frames
    task automatic make_frame();
        int           r;
        int           b;
        int           bar;
        logic [15:0]  ceil;
        t_frame_shape shape;
        r     = $urandom_range(0, 9);
        shape = (r < 6) ? SHAPE_FULL : t_frame_shape'(r - 5);
        case ($urandom_range(0, 3))
            0: ceil = 16'hFFFF;
            1: ceil = 16'h1200;
            2: ceil = 16'h0400;
            default: ceil = 16'($urandom_range(0, 65535));
        endcase
        case (shape)
            SHAPE_FULL: begin
                for (b = 0; b < BAR_BINS; b++) push_rand(b, ceil);
                repeat ($urandom_range(0, 3)) push_rand($urandom_range(BAR_BINS, 255), ceil);
            end
            SHAPE_SKIP: begin
                b = $urandom_range(0, 20);
                while (b < BAR_BINS) begin
                    push_rand(b, ceil);
                    b += $urandom_range(1, 4);
                end
            end
            SHAPE_NOISE: begin
                repeat (30) push_rand($urandom_range(0, 255), ceil);
            end
            SHAPE_BARS: begin
                repeat (4) begin
                    bar = $urandom_range(0, NUM_BARS - 1);
                    for (b = 0; b < BINS_PER_BAR; b++) push_rand(bar * BINS_PER_BAR + b, ceil);
                end
            end
            default: begin
                for (bar = NUM_BARS - 1; bar >= 0; bar--)
                    for (b = 0; b < BINS_PER_BAR; b++) push_rand(bar * BINS_PER_BAR + b, ceil);
            end
        endcase
    endtask

    // wait until every queued bin is taken and every bar word has come back
    task automatic drain();
        while (pend_bins.size() != 0 || in_valid || bar_exp.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_USE_NORM) use_norm_q = val[0];
        else decay_q = val;
        cfg_writes++;
    endtask

    task automatic random_phase();
        int goal;
        goal = bins_made + PHASE_BINS;
        while (bins_made < goal) make_frame();
        drain();
    endtask

    // select bit rides with random upper bits, which must be ignored
    function automatic logic [15:0] norm_sel(input logic on);
        return {15'($urandom_range(0, 32767)), on};
    endfunction

    // stimulus and phase sequencing
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored bins
        push_bin(BAR_BINS, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_bin(255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // full bar 0 with a full-scale bin, then a bare last bin to decay it
        for (int b = 0; b < BINS_PER_BAR; b++)
            push_bin(b, (b == 5) ? 16'hFFFF : 16'(b * 16), 16'h0000, 16'hFFFF);
        push_bin(BINS_PER_BAR - 1, 16'h0000, 16'hFFFF, 16'hFFFF);
        // peak marker either side of the limit
        push_bin(2 * BINS_PER_BAR - 1, 16'h1000, 16'h0000, 16'h0000);
        push_bin(2 * BINS_PER_BAR - 1, 16'h10FF, 16'h0000, 16'h0000);
        push_bin(2 * BINS_PER_BAR - 1, 16'h1100, 16'h0000, 16'h0000);
        // last bar alone
        push_bin(BAR_BINS - 1, 16'h0001, 16'h0000, 16'h0000);
        // out of order bins across bars 2 and 3
        push_bin(3 * BINS_PER_BAR, 16'hFFFF, 16'h0000, 16'h1234);
        push_bin(2 * BINS_PER_BAR + 2, 16'h0010, 16'h0000, 16'h1234);
        push_bin(3 * BINS_PER_BAR - 1, 16'h0020, 16'h0000, 16'h1234);
        push_bin(2 * BINS_PER_BAR, 16'h0020, 16'h0000, 16'h8000);
        push_bin(3 * BINS_PER_BAR - 1, 16'h0010, 16'h0000, 16'h8000);
        drain();

        // reset settings, raw magnitude and default decay
        random_phase();

        // normalized magnitude, fastest decay clamps peaks
        write_reg(CFG_USE_NORM, norm_sel(1'b1));
        write_reg(CFG_DECAY, 16'hFFFF);
        random_phase();

        // no decay at all
        write_reg(CFG_DECAY, 16'h0000);
        random_phase();

        // raw magnitude, random decay
        write_reg(CFG_USE_NORM, norm_sel(1'b0));
        write_reg(CFG_DECAY, 16'($urandom_range(0, 65535)));
        random_phase();

        // normalized magnitude, slow decay
        write_reg(CFG_USE_NORM, norm_sel(1'b1));
        write_reg(CFG_DECAY, 16'($urandom_range(1, 64)));
        random_phase();

        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("%0d bin words taken, %0d bar words checked", bins_taken, words_checked);
        $display("%0d register writes between the random phases", cfg_writes);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 600000);
        $display("timeout with %0d bar words still pending", bar_exp.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
